// ===== rtl/core/arp_pkg.sv =====
// Shared types, codes and decode helper for the ARP cache and responder.
// No dependencies; every other file imports this package.
package arp_pkg;

    // Cache geometry default
    localparam int ARP_ENTRIES = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd1;

    // Operation codes
    localparam logic [1:0] OP_PKT    = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_ADD    = 2'd2;

    // Status codes
    localparam logic [2:0] ST_REQ_LEARNED = 3'd0;
    localparam logic [2:0] ST_REP_LEARNED = 3'd1;
    localparam logic [2:0] ST_ADDED       = 3'd2;
    localparam logic [2:0] ST_HIT         = 3'd3;
    localparam logic [2:0] ST_MISS        = 3'd4;
    localparam logic [2:0] ST_SHORT       = 3'd5;
    localparam logic [2:0] ST_BAD_TYPE    = 3'd6;
    localparam logic [2:0] ST_BAD_OPCODE  = 3'd7;

    // ARP header constants
    localparam logic [10:0] ARP_MIN_LEN  = 11'd28;
    localparam logic [15:0] HW_ETHERNET  = 16'h0001;
    localparam logic [15:0] PROTO_IPV4   = 16'h0800;
    localparam logic [15:0] OPC_REQUEST  = 16'h0001;
    localparam logic [15:0] OPC_REPLY    = 16'h0002;

    typedef struct packed {
        logic [1:0]  op;
        logic [10:0] pkt_len;
        logic [15:0] hw_type;
        logic [15:0] prot_type;
        logic [15:0] arp_opcode;
        logic [31:0] peer_ip;
        logic [47:0] peer_mac;
        logic [31:0] tgt_ip;
    } arp_cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        send_reply;
        logic [47:0] reply_mac;
        logic [31:0] reply_ip;
        logic [47:0] found_mac;
        logic        overwrote_first;
    } arp_res_t;

    // Search token walking down the row of cells
    typedef struct packed {
        logic        vld;
        logic        hit;
        logic        free;
        logic [31:0] ip;
        logic [47:0] mac;
    } arp_tok_t;

    // Broadcast write into the row; the cell index travels beside it
    typedef struct packed {
        logic        en;
        logic [31:0] ip;
        logic [47:0] mac;
    } arp_wr_t;

    // Decoded command
    typedef struct packed {
        logic [2:0] status;
        logic       learn;
        logic       lookup;
    } arp_dec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } arp_state_t;

    // Classify a command: fixed status, and whether it needs the cache
    function automatic arp_dec_t arp_decode(arp_cmd_t c);
        arp_dec_t d;
        d.status = ST_BAD_OPCODE;
        d.learn  = 1'b0;
        d.lookup = 1'b0;
        unique case (c.op)
            OP_ADD:
            begin
                d.status = ST_ADDED;
                d.learn  = 1'b1;
            end
            OP_LOOKUP:
            begin
                d.status = ST_MISS;
                d.lookup = 1'b1;
            end
            OP_PKT:
            begin
                priority if (c.pkt_len < ARP_MIN_LEN)
                begin
                    d.status = ST_SHORT;
                end
                else if (c.hw_type != HW_ETHERNET || c.prot_type != PROTO_IPV4)
                begin
                    d.status = ST_BAD_TYPE;
                end
                else if (c.arp_opcode == OPC_REQUEST)
                begin
                    d.status = ST_REQ_LEARNED;
                    d.learn  = 1'b1;
                end
                else if (c.arp_opcode == OPC_REPLY)
                begin
                    d.status = ST_REP_LEARNED;
                    d.learn  = 1'b1;
                end
                else
                begin
                    d.status = ST_BAD_OPCODE;
                end
            end
            default:
            begin
                d.status = ST_BAD_OPCODE;
            end
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/arp_cmd_if.sv =====
// Command channel interface: valid/ready handshake with an ARP command payload.
// Depends on arp_pkg.
interface arp_cmd_if import arp_pkg::*; ();
    logic     valid;
    logic     ready;
    arp_cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/arp_res_if.sv =====
// Result channel interface: valid/ready handshake with an ARP result payload.
// Depends on arp_pkg.
interface arp_res_if import arp_pkg::*; ();
    logic     valid;
    logic     ready;
    arp_res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/arp_cell.sv =====
// One cache entry of the search row: holds IP, MAC and valid, compares the
// passing token and registers it for the next cell. Depends on arp_pkg.
module arp_cell import arp_pkg::*;
#(
    parameter int IDX_W  = 4,
    parameter int MY_IDX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  arp_tok_t         tok_i,
    input  logic [IDX_W-1:0] hit_idx_i,
    input  logic [IDX_W-1:0] free_idx_i,
    output arp_tok_t         tok_o,
    output logic [IDX_W-1:0] hit_idx_o,
    output logic [IDX_W-1:0] free_idx_o,
    input  arp_wr_t          wr,
    input  logic [IDX_W-1:0] wr_idx
);

    localparam logic [IDX_W-1:0] SELF = IDX_W'(MY_IDX);

    logic             valid_reg;
    logic [31:0]      ip_reg;
    logic [47:0]      mac_reg;
    arp_tok_t         tok_reg, tok_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             sel;
    logic             match;
    logic             vacant;

    assign sel = wr.en && (wr_idx == SELF);

    // Entry valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel)
        begin
            valid_reg <= 1'b1;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            ip_reg  <= wr.ip;
            mac_reg <= wr.mac;
        end
    end

    // Compare: first valid match wins, first vacant entry is remembered
    always_comb
    begin
        match  = tok_i.vld && !tok_i.hit && valid_reg && (ip_reg == tok_i.ip);
        vacant = tok_i.vld && !tok_i.free && !valid_reg;

        tok_next      = tok_i;
        hit_idx_next  = hit_idx_i;
        free_idx_next = free_idx_i;
        if (match)
        begin
            tok_next.hit = 1'b1;
            tok_next.mac = mac_reg;
            hit_idx_next = SELF;
        end
        if (vacant)
        begin
            tok_next.free = 1'b1;
            free_idx_next = SELF;
        end
    end

    // Token stage towards the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    assign tok_o      = tok_reg;
    assign hit_idx_o  = hit_idx_reg;
    assign free_idx_o = free_idx_reg;

endmodule

// ===== rtl/core/arp_cache_and_responder.sv =====
// ARP cache and responder. Commands that use the cache (add, lookup, valid
// request/reply) send a search token down the row, one cell per cycle;
// rejected packets skip the search. One command at a time: the next is taken
// once the last result is registered, which waits while res.ready holds it off.
// Reset (rst_n, async low) clears all entry valid bits, own_ip and the FSM.
module arp_cache_and_responder import arp_pkg::*;
#(
    parameter int ENTRIES = ARP_ENTRIES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    arp_cmd_if.sink               cmd,
    arp_res_if.source             res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    arp_state_t       state_reg, state_next;
    arp_cmd_t         item_reg;
    arp_dec_t         dec_reg, dec_in;
    arp_tok_t         start_reg, start_next;
    logic [31:0]      own_ip_reg;
    logic             res_valid_reg, res_valid_next;
    arp_res_t         res_data_reg, res_data_next;
    logic             hit_reg, free_reg;
    logic [IDX_W-1:0] hit_idx_reg, free_idx_reg;
    logic [47:0]      hit_mac_reg;
    logic             accept;
    logic             done_fire;
    logic             needs_scan;
    arp_wr_t          wr;
    logic [IDX_W-1:0] wr_idx;

    arp_tok_t         tok [ENTRIES+1];
    logic [IDX_W-1:0] hidx [ENTRIES+1];
    logic [IDX_W-1:0] fidx [ENTRIES+1];

    assign dec_in     = arp_decode(cmd.data);
    assign needs_scan = dec_in.learn || dec_in.lookup;
    assign accept     = cmd.valid && cmd.ready;

    // Configuration: own MAC affects no result field, so only own IP is kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= '0;
        end
        else if (cfg_we && cfg_index == CFG_OWN_IP)
        begin
            own_ip_reg <= cfg_wdata[31:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = needs_scan ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (tok[ENTRIES].vld)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // FSM outputs: handshake, search launch, cache write and result
    always_comb
    begin
        cmd.ready = (state_reg == ST_IDLE);
        done_fire = (state_reg == ST_DONE) && (!res_valid_reg || res.ready);

        start_next     = '0;
        start_next.vld = accept && needs_scan;
        start_next.ip  = cmd.data.peer_ip;

        // Write target: matching entry, else first vacant, else entry 0
        wr.en  = done_fire && dec_reg.learn;
        wr.ip  = item_reg.peer_ip;
        wr.mac = item_reg.peer_mac;
        priority if (hit_reg)
        begin
            wr_idx = hit_idx_reg;
        end
        else if (free_reg)
        begin
            wr_idx = free_idx_reg;
        end
        else
        begin
            wr_idx = '0;
        end

        res_data_next                 = '0;
        res_data_next.status          = dec_reg.status;
        res_data_next.overwrote_first = dec_reg.learn && !hit_reg && !free_reg;
        if (dec_reg.lookup)
        begin
            res_data_next.status    = hit_reg ? ST_HIT : ST_MISS;
            res_data_next.found_mac = hit_reg ? hit_mac_reg : '0;
        end
        if (dec_reg.learn && dec_reg.status == ST_REQ_LEARNED
            && item_reg.tgt_ip == own_ip_reg)
        begin
            res_data_next.send_reply = 1'b1;
            res_data_next.reply_mac  = item_reg.peer_mac;
            res_data_next.reply_ip   = item_reg.peer_ip;
        end

        priority if (done_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Command capture, search summary and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd.data;
            dec_reg  <= dec_in;
        end
        if (state_reg == ST_SCAN && tok[ENTRIES].vld)
        begin
            hit_reg      <= tok[ENTRIES].hit;
            free_reg     <= tok[ENTRIES].free;
            hit_mac_reg  <= tok[ENTRIES].mac;
            hit_idx_reg  <= hidx[ENTRIES];
            free_idx_reg <= fidx[ENTRIES];
        end
        if (done_fire)
        begin
            res_data_reg <= res_data_next;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    // Row of cache cells
    assign tok[0]  = start_reg;
    assign hidx[0] = '0;
    assign fidx[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        arp_cell #(
            .IDX_W  (IDX_W),
            .MY_IDX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .tok_i      (tok[i]),
            .hit_idx_i  (hidx[i]),
            .free_idx_i (fidx[i]),
            .tok_o      (tok[i+1]),
            .hit_idx_o  (hidx[i+1]),
            .free_idx_o (fidx[i+1]),
            .wr         (wr),
            .wr_idx     (wr_idx)
        );
    end

    // The search token only leaves the row while a scan is pending
    a_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok[ENTRIES].vld |-> state_reg == ST_SCAN)
        else $error("search token left the row outside a scan");

    // A command that needs the cache goes to the scan
    a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && needs_scan) |=> state_reg == ST_SCAN)
        else $error("cache command did not start a scan");

    // Overwrite of entry 0 only reported for learning commands
    a_ovr_learn: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.data.overwrote_first) |->
        (res.data.status == ST_ADDED || res.data.status == ST_REQ_LEARNED
         || res.data.status == ST_REP_LEARNED))
        else $error("overwrite flagged on a non-learning result");

    // Replies only answer learned requests
    a_reply_req: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.data.send_reply) |-> res.data.status == ST_REQ_LEARNED)
        else $error("reply requested for a non-request result");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for arp_cache_and_responder: directed and random ARP traffic,
// with a cache mirror predicting every result. Depends on arp_pkg, arp_cmd_if and arp_res_if.
import arp_pkg::*;

// Mirror of the IPv4-to-MAC cache; predicts one result per accepted command
class arp_cache_mirror;
    logic [31:0] entry_ip [ARP_ENTRIES];
    logic [47:0] entry_mac[ARP_ENTRIES];
    bit          entry_vld[ARP_ENTRIES];
    logic [31:0] own_ip;
    logic [47:0] own_mac;
    arp_res_t    owed_results[$];
    int unsigned commands, checked, mismatches, replies, overwrites;
    int unsigned status_seen[8];

    function new();
        for (int i = 0; i < ARP_ENTRIES; i++)
        begin
            entry_ip[i]  = '0;
            entry_mac[i] = '0;
            entry_vld[i] = 1'b0;
        end
        own_ip  = '0;
        own_mac = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_OWN_IP)
            own_ip = val[31:0];
        else if (idx == CFG_OWN_MAC)
            own_mac = val;
    endfunction

    function int find_entry(logic [31:0] ip);
        for (int i = 0; i < ARP_ENTRIES; i++)
            if (entry_vld[i] && entry_ip[i] == ip)
                return i;
        return -1;
    endfunction

    // Update a known IP, else fill the lowest free slot, else replace slot 0
    function bit learn_pair(logic [31:0] ip, logic [47:0] mac);
        int idx;
        idx = find_entry(ip);
        if (idx >= 0)
        begin
            entry_mac[idx] = mac;
            return 1'b0;
        end
        for (int i = 0; i < ARP_ENTRIES; i++)
        begin
            if (!entry_vld[i])
            begin
                entry_ip[i]  = ip;
                entry_mac[i] = mac;
                entry_vld[i] = 1'b1;
                return 1'b0;
            end
        end
        entry_ip[0]  = ip;
        entry_mac[0] = mac;
        entry_vld[0] = 1'b1;
        return 1'b1;
    endfunction

    // Accepted command transaction: predict its result and queue it
    function void take_command(arp_cmd_t c);
        arp_res_t r;
        int       idx;
        r = '0;
        r.status = ST_BAD_OPCODE;
        if (c.op == OP_ADD)
        begin
            r.overwrote_first = learn_pair(c.peer_ip, c.peer_mac);
            r.status = ST_ADDED;
        end
        else if (c.op == OP_LOOKUP)
        begin
            idx = find_entry(c.peer_ip);
            if (idx >= 0)
            begin
                r.status    = ST_HIT;
                r.found_mac = entry_mac[idx];
            end
            else
                r.status = ST_MISS;
        end
        else if (c.op == OP_PKT)
        begin
            if (c.pkt_len < ARP_MIN_LEN)
                r.status = ST_SHORT;
            else if (c.hw_type != HW_ETHERNET || c.prot_type != PROTO_IPV4)
                r.status = ST_BAD_TYPE;
            else if (c.arp_opcode == OPC_REQUEST)
            begin
                r.overwrote_first = learn_pair(c.peer_ip, c.peer_mac);
                r.status = ST_REQ_LEARNED;
                // only a request aimed at us gets answered
                if (c.tgt_ip == own_ip)
                begin
                    r.send_reply = 1'b1;
                    r.reply_mac  = c.peer_mac;
                    r.reply_ip   = c.peer_ip;
                end
            end
            else if (c.arp_opcode == OPC_REPLY)
            begin
                r.overwrote_first = learn_pair(c.peer_ip, c.peer_mac);
                r.status = ST_REP_LEARNED;
            end
        end
        commands++;
        status_seen[r.status]++;
        if (r.send_reply)
            replies++;
        if (r.overwrote_first)
            overwrites++;
        owed_results.push_back(r);
    endfunction

    // Accepted result transaction: compare against the oldest prediction
    function void match_result(arp_res_t got);
        arp_res_t want;
        string    diffs;
        checked++;
        if (owed_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result with status %0d arrived with nothing outstanding",
                         got.status);
            return;
        end
        want  = owed_results.pop_front();
        diffs = "";
        if (got.status !== want.status)
            diffs = {diffs, " status"};
        if (got.send_reply !== want.send_reply)
            diffs = {diffs, " send_reply"};
        if (got.reply_mac !== want.reply_mac)
            diffs = {diffs, " reply_mac"};
        if (got.reply_ip !== want.reply_ip)
            diffs = {diffs, " reply_ip"};
        if (got.found_mac !== want.found_mac)
            diffs = {diffs, " found_mac"};
        if (got.overwrote_first !== want.overwrote_first)
            diffs = {diffs, " overwrote_first"};
        if (diffs != "")
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("ERROR: result %0d wrong in%s", checked, diffs);
                $display("  expected st=%0d rep=%b rmac=%h rip=%h fmac=%h ovr=%b",
                         want.status, want.send_reply, want.reply_mac, want.reply_ip,
                         want.found_mac, want.overwrote_first);
                $display("  actual   st=%0d rep=%b rmac=%h rip=%h fmac=%h ovr=%b",
                         got.status, got.send_reply, got.reply_mac, got.reply_ip,
                         got.found_mac, got.overwrote_first);
            end
        end
    endfunction

    function int outstanding();
        return owed_results.size();
    endfunction
endclass

module tb_top;

    localparam logic [1:0] OP_UNUSED        = 2'd3;
    localparam int         RANDOM_PER_PHASE = 200;
    localparam int         SETTLE_CYCLES    = ARP_ENTRIES + 8;
    localparam int         CYCLE_LIMIT      = 400000;
    localparam int         POOL_SIZE        = 24;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    arp_cmd_if cmd ();
    arp_res_if res ();

    arp_cache_mirror mirror;
    logic [31:0]     ip_pool[POOL_SIZE];
    logic [31:0]     cur_own_ip;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;
    int unsigned     cycle_count = 0;

    arp_cache_and_responder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd.sink),
        .res       (res.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor both channels
    always @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
            mirror.take_command(cmd.data);
        if (res.valid && res.ready)
            mirror.match_result(res.data);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, mirror.outstanding());
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly pool addresses so lookups hit and the cache fills up
    function automatic logic [31:0] pick_ip();
        if ($urandom_range(0, 99) < 85)
            return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
        return 32'($urandom);
    endfunction

    function automatic arp_cmd_t make_cmd(logic [1:0] op, logic [10:0] len, logic [15:0] hw,
                                          logic [15:0] proto, logic [15:0] opc,
                                          logic [31:0] pip, logic [47:0] pmac,
                                          logic [31:0] tip);
        arp_cmd_t c;
        c.op         = op;
        c.pkt_len    = len;
        c.hw_type    = hw;
        c.prot_type  = proto;
        c.arp_opcode = opc;
        c.peer_ip    = pip;
        c.peer_mac   = pmac;
        c.tgt_ip     = tip;
        return c;
    endfunction

    // Random command: mostly well-formed packets, adds and lookups, some broken packets
    function automatic arp_cmd_t gen_random_cmd();
        arp_cmd_t    c;
        int unsigned pick;
        c = make_cmd(2'($urandom), 11'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), pick_ip(), rand_mac(), 32'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 28)
            c.op = OP_ADD;
        else if (pick < 56)
            c.op = OP_LOOKUP;
        else if (pick < 96)
            c.op = OP_PKT;
        else
            c.op = OP_UNUSED;
        if (c.op == OP_PKT)
        begin
            c.pkt_len    = 11'($urandom_range(28, 2047));
            c.hw_type    = HW_ETHERNET;
            c.prot_type  = PROTO_IPV4;
            c.arp_opcode = ($urandom_range(0, 1) == 0) ? OPC_REQUEST : OPC_REPLY;
            c.tgt_ip     = ($urandom_range(0, 1) == 0) ? cur_own_ip : pick_ip();
            pick = $urandom_range(0, 99);
            if (pick < 7)
                c.pkt_len = 11'($urandom_range(0, 27));
            else if (pick < 11)
                c.hw_type = 16'($urandom);
            else if (pick < 15)
                c.prot_type = 16'($urandom);
            else if (pick < 20)
                c.arp_opcode = 16'($urandom);
        end
        return c;
    endfunction

    // Present one command transaction, with random gaps ahead of it
    task automatic drive_command(arp_cmd_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.data  <= c;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
    endtask

    // Stop sending until every outstanding result is back, then let the block settle
    task automatic drain_results();
        cmd.valid <= 1'b0;
        while (mirror.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers; only called while the block is idle
    task automatic apply_settings(logic [31:0] ip, logic [47:0] mac);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OWN_IP;
        cfg_wdata <= {16'h0, ip};
        @(posedge clk);
        cfg_index <= CFG_OWN_MAC;
        cfg_wdata <= mac;
        @(posedge clk);
        cfg_we <= 1'b0;
        mirror.write_reg(CFG_OWN_IP, {16'h0, ip});
        mirror.write_reg(CFG_OWN_MAC, mac);
        cur_own_ip = ip;
    endtask

    initial
    begin
        mirror        = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        cmd.valid     = 1'b0;
        cmd.data      = '0;
        cur_own_ip    = '0;
        send_idle_pct = 7;
        recv_idle_pct = 68;
        for (int i = 0; i < POOL_SIZE; i++)
            ip_pool[i] = $urandom;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        apply_settings(32'hC0A8_0001, 48'h0200_5E00_0001);
        drive_command(make_cmd(OP_LOOKUP, 11'd0, 16'h0, 16'h0, 16'h0,
                               32'h0A00_0001, 48'h0, 32'h0));
        drive_command(make_cmd(OP_ADD, 11'd0, 16'h0, 16'h0, 16'h0,
                               32'h0, 48'h0, 32'h0));
        drive_command(make_cmd(OP_ADD, 11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        drive_command(make_cmd(OP_LOOKUP, 11'd0, 16'h0, 16'h0, 16'h0,
                               32'hFFFF_FFFF, 48'h0, 32'h0));
        // update of an existing entry, then read it back
        drive_command(make_cmd(OP_ADD, 11'd0, 16'h0, 16'h0, 16'h0,
                               32'h0, 48'h0123_4567_89AB, 32'h0));
        drive_command(make_cmd(OP_LOOKUP, 11'd0, 16'h0, 16'h0, 16'h0,
                               32'h0, 48'h0, 32'h0));
        // short packets
        drive_command(make_cmd(OP_PKT, 11'd0, HW_ETHERNET, PROTO_IPV4, OPC_REQUEST,
                               32'h0A00_0009, 48'h1, 32'hC0A8_0001));
        drive_command(make_cmd(OP_PKT, 11'd27, HW_ETHERNET, PROTO_IPV4, OPC_REQUEST,
                               32'h0A00_0009, 48'h1, 32'hC0A8_0001));
        // request for us at the minimum length, reply at the maximum
        drive_command(make_cmd(OP_PKT, 11'd28, HW_ETHERNET, PROTO_IPV4, OPC_REQUEST,
                               32'h0A00_0002, 48'hAABB_CCDD_EEFF, 32'hC0A8_0001));
        drive_command(make_cmd(OP_PKT, 11'h7FF, HW_ETHERNET, PROTO_IPV4, OPC_REPLY,
                               32'h0A00_0003, 48'h1122_3344_5566, 32'hC0A8_0001));
        // wrong hardware or protocol type
        drive_command(make_cmd(OP_PKT, 11'd28, 16'h0, PROTO_IPV4, OPC_REQUEST,
                               32'h0A00_0009, 48'h1, 32'hC0A8_0001));
        drive_command(make_cmd(OP_PKT, 11'd64, 16'hFFFF, PROTO_IPV4, OPC_REQUEST,
                               32'h0A00_0009, 48'h1, 32'hC0A8_0001));
        drive_command(make_cmd(OP_PKT, 11'd28, HW_ETHERNET, 16'h86DD, OPC_REPLY,
                               32'h0A00_0009, 48'h1, 32'hC0A8_0001));
        // unknown ARP opcode, unused op value
        drive_command(make_cmd(OP_PKT, 11'd28, HW_ETHERNET, PROTO_IPV4, 16'h0,
                               32'h0A00_0009, 48'h1, 32'hC0A8_0001));
        drive_command(make_cmd(OP_UNUSED, 11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        // request for someone else: learned, not answered
        drive_command(make_cmd(OP_PKT, 11'd42, HW_ETHERNET, PROTO_IPV4, OPC_REQUEST,
                               32'h0A00_0004, 48'h0000_0000_0A04, 32'h0A00_00FE));
        // fill the remaining slots, then force a replacement of slot 0 by a learn
        for (int i = 0; i < ARP_ENTRIES - 5; i++)
            drive_command(make_cmd(OP_ADD, 11'd0, 16'h0, 16'h0, 16'h0,
                                   32'h0A01_0000 + i, rand_mac(), 32'h0));
        drive_command(make_cmd(OP_PKT, 11'd28, HW_ETHERNET, PROTO_IPV4, OPC_REPLY,
                               32'h0A02_0000, 48'h0000_0BAD_0000, 32'h0));
        drive_command(make_cmd(OP_LOOKUP, 11'd0, 16'h0, 16'h0, 16'h0,
                               32'h0A02_0000, 48'h0, 32'h0));
        drain_results();

        // Random phases: sender-light, receiver-light, then no idling
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 0)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 68;
                apply_settings(32'h0, 48'h0);
            end
            else if (phase == 1)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 7;
                apply_settings(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                apply_settings($urandom, rand_mac());
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                drive_command(gen_random_cmd());
            drain_results();
        end

        if (mirror.outstanding() != 0)
        begin
            $display("ERROR: %0d expected results never arrived", mirror.outstanding());
            mirror.mismatches += mirror.outstanding();
        end
        $display("Run: %0d commands, %0d results checked, %0d mismatches",
                 mirror.commands, mirror.checked, mirror.mismatches);
        $display("Seen: %0d hits, %0d misses, %0d replies owed, %0d slot-0 replacements",
                 mirror.status_seen[ST_HIT], mirror.status_seen[ST_MISS],
                 mirror.replies, mirror.overwrites);
        if (mirror.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/arp_pkg.sv
rtl/core/arp_cmd_if.sv
rtl/core/arp_res_if.sv
rtl/core/arp_cell.sv
rtl/core/arp_cache_and_responder.sv
verif/tb_top.sv
